// ----- rtl/glos_pkg.sv -----
// Package for the grid line-of-sight checker.
// Holds the walker state type, register indexes, operation codes and widths.
// No dependencies.
package glos_pkg;

  localparam int DefMaxColumns = 256;
  localparam int DefMaxRows    = 256;

  localparam int CellW   = 8;
  localparam int CoordW  = 11;
  localparam int PosW    = 12;
  localparam int ErrW    = 14;
  localparam int CfgW    = 9;
  localparam int CfgIdxW = 2;
  localparam int SizeW   = 11;

  localparam logic [CfgIdxW-1:0] CFG_MAP_COLUMNS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAP_ROWS    = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } walk_state_e;

endpackage

// ----- rtl/glos_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the occupancy grid; no dependencies.
module glos_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/grid_line_of_sight_checker.sv -----
// Top level of the grid line-of-sight checker: request handshake, Bresenham walker
// and result register. Depends on glos_pkg and glos_ram.
//
// A write request stores one bit into the occupancy grid RAM when its cell lies
// inside MaxColumns by MaxRows. A query request loads the end points and the map
// size when it is accepted; the walker then reads one visited cell per cycle and
// registers the result once the output is free. The walk stops at the first
// blocked cell or the first cell outside the map, so it visits at most the larger
// of MaxColumns and MaxRows cells. The walker uses the single grid read port once
// per cell, while separate step logic advances x, y and the error term.
// The block takes no new request until the query is finished, but a finished
// result may wait at the output while the next request is taken. The grid is not
// cleared after reset; cells must be written before a query reads them.
module grid_line_of_sight_checker #(
  parameter int MaxColumns = glos_pkg::DefMaxColumns,
  parameter int MaxRows    = glos_pkg::DefMaxRows
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [glos_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [glos_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic [glos_pkg::CellW-1:0]         cell_x_i,
  input  logic [glos_pkg::CellW-1:0]         cell_y_i,
  input  logic [glos_pkg::CellW-1:0]         cell_value_i,
  input  logic signed [glos_pkg::CoordW-1:0] start_x_i,
  input  logic signed [glos_pkg::CoordW-1:0] start_y_i,
  input  logic signed [glos_pkg::CoordW-1:0] end_x_i,
  input  logic signed [glos_pkg::CoordW-1:0] end_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               blocked_o
);

  localparam int XW    = $clog2(MaxColumns);
  localparam int YW    = $clog2(MaxRows);
  localparam int AW    = XW + YW;
  localparam int Depth = MaxRows * (2 ** XW);
  localparam int PW    = glos_pkg::PosW;
  localparam int EW    = glos_pkg::ErrW;
  localparam int SW    = glos_pkg::SizeW;
  localparam int DW    = glos_pkg::CoordW;

  glos_pkg::walk_state_e state_q, state_d;

  logic [glos_pkg::CfgW-1:0] cfg_cols_q, cfg_rows_q;
  logic [SW-1:0]             cols_q, rows_q, cols_eff, rows_eff;
  logic signed [PW-1:0]      x_q, y_q, x1_q, y1_q;
  logic signed [PW-1:0]      x_d, y_d;
  logic [DW-1:0]             dx_q, dy_q, dx_in, dy_in;
  logic signed [PW-1:0]      diff_x, diff_y;
  logic                      sx_neg_q, sy_neg_q;
  logic signed [EW-1:0]      err_q, err_d;
  logic signed [EW:0]        e2, neg_dy, dx_ext;
  logic                      step_x, step_y;
  logic                      pend_q, last_q;
  logic                      out_valid_q, blocked_q;

  logic          in_accept, query_accept, wr_in_range;
  logic          out_free, at_end, oob;
  logic          ram_we, rd_en, fin_req, fin, fin_blk, fin_blk_req;
  logic          ram_rdata;
  logic [AW-1:0] waddr, raddr;

  assign in_accept    = in_valid_i && in_ready_o;
  assign query_accept = in_accept && (op_i == glos_pkg::OP_QUERY);
  assign out_free     = !out_valid_q || out_ready_i;

  assign wr_in_range = ({3'b000, cell_x_i} < SW'(MaxColumns))
                    && ({3'b000, cell_y_i} < SW'(MaxRows));
  assign waddr = {YW'(cell_y_i), XW'(cell_x_i)};
  assign raddr = {y_q[YW-1:0], x_q[XW-1:0]};

  assign cols_eff = ({2'b00, cfg_cols_q} > SW'(MaxColumns)) ? SW'(MaxColumns)
                                                            : {2'b00, cfg_cols_q};
  assign rows_eff = ({2'b00, cfg_rows_q} > SW'(MaxRows)) ? SW'(MaxRows)
                                                         : {2'b00, cfg_rows_q};

  assign diff_x = PW'(end_x_i) - PW'(start_x_i);
  assign diff_y = PW'(end_y_i) - PW'(start_y_i);
  assign dx_in  = diff_x[PW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign dy_in  = diff_y[PW-1] ? DW'(-diff_y) : DW'(diff_y);

  assign oob    = x_q[PW-1] || y_q[PW-1] || (x_q[SW-1:0] >= cols_q)
               || (y_q[SW-1:0] >= rows_q);
  assign at_end = (x_q == x1_q) && (y_q == y1_q);

  assign e2     = {err_q, 1'b0};
  assign neg_dy = -$signed({{(EW + 1 - DW) {1'b0}}, dy_q});
  assign dx_ext = $signed({{(EW + 1 - DW) {1'b0}}, dx_q});
  assign step_x = e2 > neg_dy;
  assign step_y = e2 < dx_ext;
  assign err_d  = err_q - (step_x ? EW'(dy_q) : EW'(0)) + (step_y ? EW'(dx_q) : EW'(0));
  assign x_d    = step_x ? (sx_neg_q ? x_q - PW'(1) : x_q + PW'(1)) : x_q;
  assign y_d    = step_y ? (sy_neg_q ? y_q - PW'(1) : y_q + PW'(1)) : y_q;

  always_comb begin
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    rd_en       = 1'b0;
    fin_req     = 1'b0;
    fin_blk_req = 1'b0;
    case (state_q)
      glos_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_we     = in_valid_i && (op_i == glos_pkg::OP_WRITE) && wr_in_range;
      end
      glos_pkg::ST_WALK: begin
        if (pend_q && ram_rdata) begin
          fin_req     = 1'b1;
          fin_blk_req = 1'b1;
        end else if (pend_q && last_q) begin
          fin_req = 1'b1;
        end else if (oob) begin
          fin_req     = 1'b1;
          fin_blk_req = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    fin     = fin_req && out_free;
    fin_blk = fin_blk_req;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      glos_pkg::ST_IDLE: begin
        if (query_accept) begin
          state_d = glos_pkg::ST_WALK;
        end
      end
      glos_pkg::ST_WALK: begin
        if (fin) begin
          state_d = glos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glos_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= glos_pkg::ST_IDLE;
      cfg_cols_q  <= glos_pkg::CfgW'(256);
      cfg_rows_q  <= glos_pkg::CfgW'(256);
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_idx_i == glos_pkg::CFG_MAP_COLUMNS)) begin
        cfg_cols_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == glos_pkg::CFG_MAP_ROWS)) begin
        cfg_rows_q <= cfg_wdata_i;
      end
      if (query_accept || fin) begin
        pend_q <= 1'b0;
      end else if (rd_en) begin
        pend_q <= 1'b1;
      end
      if (rd_en) begin
        last_q <= at_end;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_accept) begin
      x_q      <= PW'(start_x_i);
      y_q      <= PW'(start_y_i);
      x1_q     <= PW'(end_x_i);
      y1_q     <= PW'(end_y_i);
      dx_q     <= dx_in;
      dy_q     <= dy_in;
      sx_neg_q <= !(start_x_i < end_x_i);
      sy_neg_q <= !(start_y_i < end_y_i);
      err_q    <= EW'(dx_in) - EW'(dy_in);
      cols_q   <= cols_eff;
      rows_q   <= rows_eff;
    end else if (rd_en) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
    if (fin) begin
      blocked_q <= fin_blk;
    end
  end

  glos_ram #(
    .Width(1),
    .Depth(Depth)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(cell_value_i != '0),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;

  // The walker only reads cells that passed the bounds check.
  a_read_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (!x_q[PW-1] && !y_q[PW-1] && (x_q[SW-1:0] < cols_q)
               && (y_q[SW-1:0] < rows_q)))
    else $error("grid read outside the configured map");

  // The grid is never written while a query walks it.
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == glos_pkg::ST_IDLE))
    else $error("grid write during a query");

  // A new result appears only at the end of a walk.
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == glos_pkg::ST_WALK))
    else $error("result without a query");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !fin)
    else $error("result overwritten while stalled");

endmodule

// ----- test/tb_grid_line_of_sight_checker.sv -----
// Self-checking testbench for grid_line_of_sight_checker: random cell writes and line queries
// against an in-bench Bresenham walk over a shadow occupancy grid, under several map sizes.
// Depends on glos_pkg and the grid_line_of_sight_checker RTL.
module tb_grid_line_of_sight_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CellW         = glos_pkg::CellW;
  localparam int CoordW        = glos_pkg::CoordW;
  localparam int CfgW          = glos_pkg::CfgW;
  localparam int CfgIdxW       = glos_pkg::CfgIdxW;
  localparam int GridCols      = glos_pkg::DefMaxColumns;
  localparam int GridRows      = glos_pkg::DefMaxRows;
  localparam int GridCells     = GridCols * GridRows;
  localparam int WalkLimit     = 8192;
  localparam int PlanWriteCap  = 48;
  localparam int LongHold      = 500;
  localparam int SettleCycles  = 16;
  localparam int WatchdogLimit = 20000;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                     op;
    logic [CellW-1:0]         cell_x;
    logic [CellW-1:0]         cell_y;
    logic [CellW-1:0]         cell_value;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } grid_req_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i    = '0;
  logic [CfgW-1:0]          cfg_wdata_i  = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic                     op_i         = glos_pkg::OP_WRITE;
  logic [CellW-1:0]         cell_x_i     = '0;
  logic [CellW-1:0]         cell_y_i     = '0;
  logic [CellW-1:0]         cell_value_i = '0;
  logic signed [CoordW-1:0] start_x_i    = '0;
  logic signed [CoordW-1:0] start_y_i    = '0;
  logic signed [CoordW-1:0] end_x_i      = '0;
  logic signed [CoordW-1:0] end_y_i      = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic                     blocked_o;

  grid_req_t pending_reqs[$];
  bit        expected_blocked[$];

  bit line_grid    [GridCells];
  bit plan_grid    [GridCells];
  bit plan_written [GridCells];

  int map_columns_cfg = GridCols;
  int map_rows_cfg    = GridRows;

  bit idle_off      = 1'b0;
  int src_gap       = 0;
  int sink_gap      = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int results_taken = 0;
  int stall_cycles  = 0;

  int reqs_planned  = 0;
  int reqs_accepted = 0;
  int queries_seen  = 0;
  int blocked_seen  = 0;
  int map_settings  = 1;
  int fail_cnt      = 0;

  grid_line_of_sight_checker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_value_i(cell_value_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .blocked_o   (blocked_o)
  );

  always #5 clk_i = ~clk_i;

  // Walks the line over the chosen grid. In planning mode the walk also stops at the first
  // in-bounds cell that has not been written yet and returns its index.
  function automatic bit trace_line(input int x0, input int y0, input int x1, input int y1,
                                    input bit use_plan, output int unknown_cell);
    int cols, rows, dx, dy, sx, sy, err, e2, x, y, idx, n;
    cols = (map_columns_cfg > GridCols) ? GridCols : map_columns_cfg;
    rows = (map_rows_cfg > GridRows) ? GridRows : map_rows_cfg;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    x = x0;
    y = y0;
    unknown_cell = -1;
    for (n = 0; n < WalkLimit; n++) begin
      if (x < 0 || y < 0 || x >= cols || y >= rows) return 1'b1;
      idx = y * GridCols + x;
      if (use_plan && !plan_written[idx]) begin
        unknown_cell = idx;
        return 1'b0;
      end
      if (use_plan ? plan_grid[idx] : line_grid[idx]) return 1'b1;
      if (x == x1 && y == y1) return 1'b0;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
    return 1'b0;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
  endfunction

  task automatic report_fail(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] %s", $time, what);
  endtask

  task automatic plan_cell_write(input int x, input int y, input logic [CellW-1:0] value);
    grid_req_t r;
    r.op         = glos_pkg::OP_WRITE;
    r.cell_x     = CellW'(x);
    r.cell_y     = CellW'(y);
    r.cell_value = value;
    r.start_x    = CoordW'($urandom);
    r.start_y    = CoordW'($urandom);
    r.end_x      = CoordW'($urandom);
    r.end_y      = CoordW'($urandom);
    plan_grid[y * GridCols + x]    = (value != 0);
    plan_written[y * GridCols + x] = 1'b1;
    pending_reqs.insert(pending_reqs.size(), r);
    reqs_planned++;
  endtask

  // Writes unknown cells the walk reads, then issues the query; at most PlanWriteCap tries.
  task automatic plan_query(input int sx, input int sy, input int ex, input int ey);
    grid_req_t r;
    int        unknown, tries;
    for (tries = 0; tries < PlanWriteCap; tries++) begin
      void'(trace_line(sx, sy, ex, ey, 1'b1, unknown));
      if (unknown < 0) begin
        r.op         = glos_pkg::OP_QUERY;
        r.cell_x     = CellW'($urandom);
        r.cell_y     = CellW'($urandom);
        r.cell_value = CellW'($urandom);
        r.start_x    = CoordW'(sx);
        r.start_y    = CoordW'(sy);
        r.end_x      = CoordW'(ex);
        r.end_y      = CoordW'(ey);
        pending_reqs.insert(pending_reqs.size(), r);
        reqs_planned++;
        return;
      end
      plan_cell_write(unknown % GridCols, unknown / GridCols,
                      CellW'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : 0));
    end
  endtask

  task automatic fill_random(input int budget);
    int first, pick, cmax, rmax, sx, sy, span;
    first = reqs_planned;
    cmax = (map_columns_cfg > GridCols) ? GridCols : map_columns_cfg;
    rmax = (map_rows_cfg > GridRows) ? GridRows : map_rows_cfg;
    cmax = (cmax > 0) ? cmax - 1 : 0;
    rmax = (rmax > 0) ? rmax - 1 : 0;
    while (reqs_planned - first < budget) begin
      pick = $urandom_range(0, 99);
      sx = $urandom_range(0, cmax);
      sy = $urandom_range(0, rmax);
      span = ($urandom_range(0, 9) == 0) ? 300 : 12;
      if (pick < 15) begin
        plan_cell_write($urandom_range(0, 255), $urandom_range(0, 255),
                        CellW'($urandom_range(0, 1) ? $urandom_range(0, 255) : 0));
      end else if (pick < 25) begin
        plan_query(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                   int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024);
      end else if (pick < 33) begin
        plan_query(sx, sy, sx, sy);
      end else if (pick < 37) begin
        plan_query(0, sy, cmax + int'($urandom_range(0, 1)), sy);
      end else if (pick < 41) begin
        plan_query(sx, rmax + int'($urandom_range(0, 1)), sx, 0);
      end else begin
        plan_query(sx, sy, clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span),
                   clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span));
      end
    end
  endtask

  task automatic issue_reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == glos_pkg::CFG_MAP_COLUMNS) map_columns_cfg = value;
    else if (idx == glos_pkg::CFG_MAP_ROWS) map_rows_cfg = value;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_blocked.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input int cols, input int rows, input int budget, input bit quiet);
    wait_drained();
    issue_reg_write(glos_pkg::CFG_MAP_COLUMNS, CfgW'(cols));
    issue_reg_write(glos_pkg::CFG_MAP_ROWS, CfgW'(rows));
    issue_reg_write((map_settings % 2 != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                    CfgW'($urandom_range(0, 511)));
    @(negedge clk_i);
    map_settings++;
    idle_off = quiet;
    fill_random(budget);
  endtask

  // Request side: holds each request until it is taken; random gaps unless idle_off is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) pending_reqs.delete(0);
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (!idle_off && pending_reqs.size() != 0 && $urandom_range(0, 4) == 0) begin
          src_gap = $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid_i   <= 1'b1;
          op_i         <= pending_reqs[0].op;
          cell_x_i     <= pending_reqs[0].cell_x;
          cell_y_i     <= pending_reqs[0].cell_y;
          cell_value_i <= pending_reqs[0].cell_value;
          start_x_i    <= pending_reqs[0].start_x;
          start_y_i    <= pending_reqs[0].start_y;
          end_x_i      <= pending_reqs[0].end_x;
          end_y_i      <= pending_reqs[0].end_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls plus one long hold so that the block backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_taken >= 60) begin
        hold_done = 1'b1;
        hold_left = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        sink_gap = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int  unused_cell;
    bit  want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_blocked.size() == 0) begin
          report_fail($sformatf("result blocked=%0b arrived with no query outstanding",
                                blocked_o));
        end else begin
          want = expected_blocked.pop_front();
          if (blocked_o !== want)
            report_fail($sformatf("blocked mismatch: expected %0b, got %0b", want, blocked_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        reqs_accepted++;
        if (op_i == glos_pkg::OP_WRITE) begin
          if (int'(cell_x_i) < GridCols && int'(cell_y_i) < GridRows)
            line_grid[int'(cell_y_i) * GridCols + int'(cell_x_i)] = (cell_value_i != 0);
        end else begin
          want = trace_line(int'(start_x_i), int'(start_y_i), int'(end_x_i), int'(end_y_i),
                            1'b0, unused_cell);
          expected_blocked.insert(expected_blocked.size(), want);
          queries_seen++;
          if (want) blocked_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles = 0;
    end else if (stall_cycles == WatchdogLimit - 1) begin
      $display("No request or result moved for %0d cycles.", WatchdogLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    plan_cell_write(0, 0, 8'h00);
    plan_cell_write(255, 255, 8'hFF);
    plan_cell_write(255, 0, 8'h01);
    plan_cell_write(0, 255, 8'h80);
    plan_cell_write(2, 0, 8'h7F);
    plan_query(0, 0, 0, 0);
    plan_query(255, 255, 255, 255);
    plan_query(-1024, -1024, 1023, 1023);
    plan_query(1023, 1023, -1024, -1024);
    plan_query(0, 0, 3, 0);
    plan_query(0, 0, 0, 3);
    plan_query(0, 3, 0, 0);
    plan_query(3, 3, 0, 0);
    plan_query(10, 3, 12, 7);
    plan_query(253, 250, 1023, 250);
    plan_query(0, 0, -1, 0);
    plan_cell_write(255, 255, 8'h00);
    plan_query(255, 255, 255, 255);
    plan_query(0, 255, 255, 0);
    fill_random(300);

    run_phase(8, 8, 250, 1'b0);
    run_phase(1, 256, 150, 1'b0);
    run_phase(0, 5, 40, 1'b0);
    run_phase(6, 0, 40, 1'b0);
    run_phase(511, 300, 300, 1'b0);
    run_phase(37, 19, 250, 1'b0);
    run_phase(256, 1, 120, 1'b0);
    run_phase(256, 256, 200, 1'b1);

    wait_drained();
    $display("Ran %0d requests through %0d map sizes, including zero and oversized settings.",
             reqs_accepted, map_settings);
    $display("Line queries: %0d, of which %0d blocked and %0d clear.",
             queries_seen, blocked_seen, queries_seen - blocked_seen);
    if (expected_blocked.size() != 0)
      report_fail($sformatf("%0d query results never arrived", expected_blocked.size()));
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
